// File: rtl/ttrc_pkg.sv
// shared constants, opcode codes and types for the three-register cpu step block
package ttrc_pkg;

  // data memory depth, a power of two from 16 to 128 (the write address field is WADDR_W = 7 bits)
  localparam int unsigned RAM_DEPTH = 128;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

  localparam int unsigned NUM_REGS  = 3;
  localparam int unsigned WADDR_W   = 7;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [7:0] {
    OP_ADD = 8'h00,
    OP_SUB = 8'h01,
    OP_JMP = 8'h02,
    OP_JNZ = 8'h03,
    OP_JZ  = 8'h04,
    OP_CMP = 8'h05,
    OP_STO = 8'h06,
    OP_MOV = 8'h07,
    OP_INC = 8'h08,
    OP_DEC = 8'h09,
    OP_STA = 8'h0A
  } opcode_e;

  // one step result, minus the ram read byte, which joins it from the registered ram read in stage 1
  typedef struct packed {
    logic [7:0]         next_pc;
    logic [7:0]         reg_a;
    logic [7:0]         reg_b;
    logic [7:0]         reg_c;
    logic               wen;
    logic [WADDR_W-1:0] waddr;
    logic [7:0]         wdata;
    logic               done;
    logic               is_read;
  } step_res_t;

endpackage

// File: rtl/ttrc_ram.sv
// generic single-port-write, registered-read ram
module ttrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tiny_three_register_cpu_step.sv
// tiny three-register cpu step: executes one instruction or one ram read per input beat.
// One beat is accepted per clock, back to back unless the output stalls; each beat gives one
// result beat (register update and ram write in the accept cycle, then a stage that picks up
// the registered ram read byte, then the output register). Registers A, B, C and the pc sit in
// flops and are updated in the accept cycle, so the next instruction sees them at once; the
// data memory is a registered-read ram, and a write in one cycle is visible to a read accepted
// in the next, so no forwarding is needed. A valid bit per ram entry, cleared by reset, makes
// unwritten bytes read as zero, so the block is ready right after reset with no clearing pass.
// program_length is written through cfg_we_i / cfg_wdata_i while the block is idle.
module tiny_three_register_cpu_step
  import ttrc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,     // program_length
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // opcode [7:0], operand_a [15:8], operand_b [23:16]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // action [0]
  input  logic [0:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // next_pc [7:0], reg_a_value [15:8], reg_b_value [23:16], reg_c_value [31:24],
  // mem_write_enable [32], mem_write_address [39:33], mem_write_data [47:40],
  // read_data [55:48]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // done_res
  output logic                  m_axis_tlast_o
);

  // architectural state
  logic [7:0]                   prog_len_q;
  logic [7:0]                   pc_q, pc_d;
  logic [NUM_REGS-1:0][7:0]     rf_q, rf_d;
  logic [RAM_DEPTH-1:0]         ram_vld_q;

  // pipeline control
  logic      s_acc;
  logic      s1_v_q;
  logic      s1_adv;
  logic      out_v_q;
  step_res_t s1_q;
  step_res_t res_d;
  logic      rd_vld_q;

  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_last_q;

  // decoded input beat
  logic        act;
  logic [7:0]  opc, opa, opb;
  logic        a_ok, b_ok, run;
  logic [7:0]  reg_opa, reg_opb;

  // ram access
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [7:0]        rd_byte;

  function automatic logic [7:0] reg_sel(input logic [NUM_REGS-1:0][7:0] rf,
                                         input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = rf[0];
      2'd1:    val = rf[1];
      2'd2:    val = rf[2];
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  assign act = s_axis_tuser_i[0];
  assign opc = s_axis_tdata_i[7:0];
  assign opa = s_axis_tdata_i[15:8];
  assign opb = s_axis_tdata_i[23:16];

  // two-deep pipe: stage 1 moves when the output register is empty or being drained
  assign s1_adv          = s1_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_v_q || s1_adv;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  assign a_ok    = (opa < 8'(NUM_REGS));
  assign b_ok    = (opb < 8'(NUM_REGS));
  assign run     = (pc_q < prog_len_q);
  assign reg_opa = reg_sel(rf_q, opa[1:0]);
  assign reg_opb = reg_sel(rf_q, opb[1:0]);

  // execute: pc advance, then the opcode; a step past the program end changes nothing
  always_comb begin
    pc_d      = pc_q;
    rf_d      = rf_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = 8'h00;
    if (s_acc && !act && run) begin
      pc_d = pc_q + 8'd1;
      case (opcode_e'(opc))
        OP_ADD: rf_d[2] = rf_q[0] + rf_q[1];
        OP_SUB: rf_d[2] = rf_q[0] - rf_q[1];
        OP_JMP: pc_d = opa;
        OP_JNZ: begin
          if (rf_q[2] != 8'h00) begin
            pc_d = opa;
          end
        end
        OP_JZ: begin
          if (rf_q[2] == 8'h00) begin
            pc_d = opa;
          end
        end
        OP_CMP: rf_d[2] = (rf_q[0] == rf_q[1]) ? 8'h00 : 8'h01;
        OP_STO: begin
          if (a_ok) begin
            ram_we    = 1'b1;
            ram_waddr = opb[RAM_AW-1:0];
            ram_wdata = reg_opa;
          end
        end
        OP_MOV: begin
          if (a_ok) begin
            rf_d[opa[1:0]] = opb;
          end
        end
        OP_INC: begin
          if (a_ok) begin
            rf_d[opa[1:0]] = reg_opa + 8'd1;
          end
        end
        OP_DEC: begin
          if (a_ok) begin
            rf_d[opa[1:0]] = reg_opa - 8'd1;
          end
        end
        OP_STA: begin
          // register value used as address, wrapped to the ram depth
          if (a_ok && b_ok) begin
            ram_we    = 1'b1;
            ram_waddr = reg_opa[RAM_AW-1:0];
            ram_wdata = reg_opb;
          end
        end
        default: ;
      endcase
    end
  end

  // read action fetches the byte; the ram output holds while stage 1 stalls
  assign ram_re    = s_acc && act;
  assign ram_raddr = opb[RAM_AW-1:0];

  always_comb begin
    res_d.next_pc = pc_d;
    res_d.reg_a   = rf_d[0];
    res_d.reg_b   = rf_d[1];
    res_d.reg_c   = rf_d[2];
    res_d.wen     = ram_we;
    res_d.waddr   = WADDR_W'(ram_waddr);
    res_d.wdata   = ram_wdata;
    res_d.done    = (pc_d >= prog_len_q);
    res_d.is_read = act;
  end

  ttrc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // state and per-entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= 8'h00;
      pc_q       <= 8'h00;
      rf_q       <= '0;
      ram_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        prog_len_q <= cfg_wdata_i;
      end
      pc_q <= pc_d;
      rf_q <= rf_d;
      if (ram_we) begin
        ram_vld_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_q <= ram_vld_q[ram_raddr];
      end
    end
  end

  // never-written bytes read as zero; execute beats report zero
  assign rd_byte = (s1_q.is_read && rd_vld_q) ? ram_rdata : 8'h00;

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        s1_v_q <= s_axis_tvalid_i;
      end
      if (!out_v_q || m_axis_tready_i) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_q <= res_d;
    end
    if (s1_adv) begin
      out_data_q <= {rd_byte, s1_q.wdata, s1_q.waddr, s1_q.wen,
                     s1_q.reg_c, s1_q.reg_b, s1_q.reg_a, s1_q.next_pc};
      out_last_q <= s1_q.done;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef ASSERT_OFF
  // ram is written only by an accepted execute beat
  a_we_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (s_acc && !act))
    else $error("ram write without accepted execute beat");

  // an accepted beat always lands in stage 1
  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> s1_v_q)
    else $error("accepted beat lost before stage 1");

  // no new beat while stage 1 is blocked
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_adv) |-> !s_acc)
    else $error("stage 1 overrun");

  // pc only moves on an accepted beat
  a_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_acc |=> $stable(pc_q))
    else $error("pc changed without a beat");

  // a step that writes ram never carries a read byte
  a_wen_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[32]) |-> (m_axis_tdata_o[55:48] == 8'h00))
    else $error("write step with read data");
`endif

endmodule

// File: tb/tiny_three_register_cpu_step_test.sv
// self-checking testbench for the three-register cpu step block
module tiny_three_register_cpu_step_test;
  import ttrc_pkg::*;

  // expected contents of one result beat
  typedef struct packed {
    logic [7:0]         next_pc;
    logic [7:0]         reg_a;
    logic [7:0]         reg_b;
    logic [7:0]         reg_c;
    logic               wen;
    logic [WADDR_W-1:0] waddr;
    logic [7:0]         wdata;
    logic [7:0]         rdata;
    logic               done;
  } step_out_t;

  // one input beat together with the result it must produce
  typedef struct {
    logic       action;
    logic [7:0] opcode;
    logic [7:0] opa;
    logic [7:0] opb;
    step_out_t  outcome;
  } instr_t;

  localparam int unsigned RANDOM_ITEMS = 1550;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [7:0]            cfg_wdata_i     = 8'h00;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [0:0]            s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;

  tiny_three_register_cpu_step dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // clock with a period of 4
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow machine state, advanced as beats are queued
  logic [7:0] gpr [NUM_REGS];
  logic [7:0] ram [RAM_DEPTH];
  logic [7:0] pc_m;
  logic [7:0] len_m;

  instr_t    instr_q[$];          // beats waiting for the driver
  step_out_t step_results_q[$];   // results owed by beats already accepted
  instr_t    in_flight;           // beat currently offered on the slave side
  instr_t    prog [256];          // program the fetcher walks through
  int        executed_n;
  int        errors;

  // idle control: a quiet flag turns off idling for a stretch
  logic      src_quiet = 1'b0;
  logic      snk_quiet = 1'b0;
  int        src_gap;
  int        snk_stall;
  int        hold_n;
  step_out_t want_r;

  // one machine step; the pc moves first, then the opcode takes effect
  function automatic step_out_t step_machine(instr_t it);
    step_out_t r;
    logic      a_ok;
    logic      b_ok;
    r = '0;
    if (it.action) begin
      r.rdata = ram[it.opb[RAM_AW-1:0]];
    end else if (pc_m < len_m) begin
      a_ok = (it.opa < NUM_REGS);
      b_ok = (it.opb < NUM_REGS);
      pc_m = pc_m + 8'd1;
      case (it.opcode)
        OP_ADD: gpr[2] = gpr[0] + gpr[1];
        OP_SUB: gpr[2] = gpr[0] - gpr[1];
        OP_JMP: pc_m = it.opa;
        OP_JNZ: if (gpr[2] != 8'd0) pc_m = it.opa;
        OP_JZ:  if (gpr[2] == 8'd0) pc_m = it.opa;
        OP_CMP: gpr[2] = (gpr[0] == gpr[1]) ? 8'd0 : 8'd1;
        OP_STO: begin
          if (a_ok) begin
            r.wen   = 1'b1;
            r.waddr = it.opb[RAM_AW-1:0];
            r.wdata = gpr[it.opa[1:0]];
          end
        end
        OP_MOV: if (a_ok) gpr[it.opa[1:0]] = it.opb;
        OP_INC: if (a_ok) gpr[it.opa[1:0]] = gpr[it.opa[1:0]] + 8'd1;
        OP_DEC: if (a_ok) gpr[it.opa[1:0]] = gpr[it.opa[1:0]] - 8'd1;
        OP_STA: begin
          if (a_ok && b_ok) begin
            r.wen   = 1'b1;
            r.waddr = gpr[it.opa[1:0]][RAM_AW-1:0];
            r.wdata = gpr[it.opb[1:0]];
          end
        end
        default: ;
      endcase
      if (r.wen) ram[r.waddr] = r.wdata;
    end
    r.next_pc = pc_m;
    r.reg_a   = gpr[0];
    r.reg_b   = gpr[1];
    r.reg_c   = gpr[2];
    r.done    = (pc_m >= len_m);
    return r;
  endfunction

  // register index, valid most of the time
  function automatic logic [7:0] reg_index();
    if ($urandom_range(0, 9) != 0) return 8'($urandom_range(0, 2));
    return 8'($urandom_range(3, 255));
  endfunction

  // jump target, mostly inside the program; 255 is never used so the pc can always recover
  function automatic logic [7:0] pick_target(logic [7:0] len);
    if (len != 8'd0 && $urandom_range(0, 7) != 0) return 8'($urandom_range(0, len - 1));
    return 8'($urandom_range(0, 254));
  endfunction

  function automatic instr_t rand_instr(logic [7:0] len);
    instr_t  it;
    int      r;
    opcode_e common [7] = '{OP_MOV, OP_STO, OP_STA, OP_MOV, OP_INC, OP_DEC, OP_CMP};
    r         = $urandom_range(0, 19);
    it.action = 1'b0;
    if (r <= 10)      it.opcode = 8'(r);
    else if (r <= 12) it.opcode = 8'($urandom_range(11, 255));
    else              it.opcode = common[r-13];
    it.opa = reg_index();
    it.opb = 8'($urandom_range(0, 255));
    case (it.opcode)
      OP_JMP, OP_JNZ, OP_JZ: it.opa = pick_target(len);
      OP_STA: it.opb = reg_index();
      default: ;
    endcase
    return it;
  endfunction

  // predict and queue one beat; ignored executes do not count as work
  task automatic issue(input logic act, input logic [7:0] op, input logic [7:0] a,
                       input logic [7:0] b);
    instr_t it;
    it.action = act;
    it.opcode = op;
    it.opa    = a;
    it.opb    = b;
    if (act || pc_m < len_m) executed_n++;
    it.outcome = step_machine(it);
    instr_q.push_back(it);
  endtask

  // wait until every queued beat has gone in and every result has come out
  task automatic drain();
    do @(negedge clk_i);
    while (instr_q.size() != 0 || s_axis_tvalid_i || step_results_q.size() != 0);
    // two-stage pipeline; let it settle before touching the register
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_length(input logic [7:0] len);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    len_m = len;
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver: offers queued beats, holds each until taken, random gap after each
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      src_gap         <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) step_results_q.push_back(in_flight.outcome);
      if ($urandom_range(0, 31) == 0) src_quiet <= ~src_quiet;
      if (s_axis_tvalid_i && !s_axis_tready_o) begin
        // beat stays on the bus until the block takes it
      end else if (src_gap != 0) begin
        src_gap         <= src_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (instr_q.size() != 0) begin
        in_flight = instr_q.pop_front();
        s_axis_tdata_i  <= {in_flight.opb, in_flight.opa, in_flight.opcode};
        s_axis_tuser_i  <= in_flight.action;
        s_axis_tvalid_i <= 1'b1;
        src_gap         <= src_quiet ? 0 : $urandom_range(0, 7);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // monitor: compares each result beat with the oldest prediction, stalls at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      snk_stall       <= 0;
    end else begin
      if ($urandom_range(0, 31) == 0) snk_quiet <= ~snk_quiet;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (step_results_q.size() == 0) begin
          $error("result beat with no prediction waiting");
          errors++;
        end else begin
          want_r = step_results_q.pop_front();
          check_field("next_pc", want_r.next_pc, m_axis_tdata_o[7:0]);
          check_field("reg_a_value", want_r.reg_a, m_axis_tdata_o[15:8]);
          check_field("reg_b_value", want_r.reg_b, m_axis_tdata_o[23:16]);
          check_field("reg_c_value", want_r.reg_c, m_axis_tdata_o[31:24]);
          check_field("mem_write_enable", 8'(want_r.wen), 8'(m_axis_tdata_o[32]));
          check_field("mem_write_address", 8'(want_r.waddr), 8'(m_axis_tdata_o[39:33]));
          check_field("mem_write_data", want_r.wdata, m_axis_tdata_o[47:40]);
          check_field("read_data", want_r.rdata, m_axis_tdata_o[55:48]);
          check_field("done_res", 8'(want_r.done), 8'(m_axis_tlast_o));
        end
        hold_n = snk_quiet ? 0 : $urandom_range(0, 7);
        snk_stall       <= hold_n;
        m_axis_tready_i <= (hold_n == 0);
      end else if (snk_stall != 0) begin
        snk_stall       <= snk_stall - 1;
        m_axis_tready_i <= (snk_stall == 1);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int     phase;
    int     n_items;
    int     r;
    int     idle_execs;
    logic [7:0] len;
    instr_t it;
    errors     = 0;
    executed_n = 0;
    pc_m       = 8'd0;
    len_m      = 8'd0;
    foreach (gpr[i]) gpr[i] = 8'd0;
    foreach (ram[i]) ram[i] = 8'd0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // program length is zero out of reset: execute is ignored, a read still works
    issue(1'b0, OP_MOV, 8'd0, 8'h55);
    issue(1'b1, 8'hFF, 8'hFF, 8'h00);

    set_length(8'd40);
    issue(1'b0, OP_MOV, 8'd0, 8'h7F);
    issue(1'b0, OP_MOV, 8'd1, 8'h01);
    issue(1'b0, OP_ADD, 8'd0, 8'd0);      // 127 + 1 wraps to -128
    issue(1'b0, OP_SUB, 8'd0, 8'd0);
    issue(1'b0, OP_MOV, 8'd0, 8'h80);
    issue(1'b0, OP_SUB, 8'd0, 8'd0);      // -128 - 1 wraps to 127
    issue(1'b0, OP_CMP, 8'd0, 8'd0);
    issue(1'b0, OP_MOV, 8'd1, 8'h7F);
    issue(1'b0, OP_INC, 8'd1, 8'd0);      // inc overflow
    issue(1'b0, OP_DEC, 8'd0, 8'd0);      // dec overflow
    issue(1'b0, OP_MOV, 8'd1, 8'h7F);
    issue(1'b0, OP_CMP, 8'd0, 8'd0);      // equal registers clear C
    issue(1'b0, OP_JNZ, 8'd20, 8'd0);     // not taken
    issue(1'b0, OP_JZ, 8'd20, 8'd0);      // taken
    issue(1'b0, OP_STO, 8'd0, 8'hFF);     // address keeps its low bits
    issue(1'b1, 8'h00, 8'h00, 8'hFF);
    issue(1'b0, OP_MOV, 8'd2, 8'hC3);
    issue(1'b0, OP_STA, 8'd2, 8'd0);      // register value used as address
    issue(1'b1, 8'hA5, 8'h5A, 8'h43);
    issue(1'b0, OP_STO, 8'd3, 8'h10);     // bad register index
    issue(1'b0, OP_MOV, 8'hFF, 8'h10);
    issue(1'b0, OP_STA, 8'd0, 8'd3);
    issue(1'b0, 8'hFF, 8'hFF, 8'hFF);     // unknown opcode
    issue(1'b0, OP_JNZ, 8'd0, 8'd0);
    issue(1'b0, OP_JMP, 8'd39, 8'd0);
    issue(1'b0, OP_ADD, 8'd0, 8'd0);      // last instruction reaches the end
    issue(1'b0, OP_INC, 8'd0, 8'd0);      // ignored once done

    set_length(8'd0);
    issue(1'b0, OP_MOV, 8'd1, 8'h22);
    issue(1'b1, 8'h00, 8'h00, 8'h7F);

    // random part: a fetcher walks a fresh random program per phase, with
    // ram reads and stray instructions mixed in
    executed_n = 0;
    phase      = 0;
    while (executed_n < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (phase == 0 || r == 1) len = 8'd255;
      else if (r == 0)          len = 8'($urandom_range(0, pc_m));
      else                      len = 8'((pc_m + 1 + $urandom_range(0, 40) > 255) ? 255 :
                                         pc_m + 1 + $urandom_range(0, 40));
      // every phase starts from an idle block, so the sender waits out all results here
      set_length(len);
      for (int i = 0; i < len; i++) prog[i] = rand_instr(len);
      n_items    = $urandom_range(10, 80);
      idle_execs = 0;
      for (int i = 0; i < n_items && idle_execs < 3; i++) begin
        r = $urandom_range(0, 19);
        if (r < 2) begin
          issue(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (r < 4 && !(len_m == 8'd255 && pc_m == 8'd254)) begin
          it.opcode = 8'($urandom);
          it.opa    = 8'($urandom);
          it.opb    = 8'($urandom);
          if ((it.opcode == OP_JMP || it.opcode == OP_JNZ || it.opcode == OP_JZ) &&
              it.opa == 8'hFF) it.opa = 8'hFE;
          issue(1'b0, it.opcode, it.opa, it.opb);
        end else if (pc_m >= len_m) begin
          // execute while done, then move on to the next phase
          it = rand_instr(len_m);
          issue(1'b0, it.opcode, it.opa, it.opb);
          idle_execs++;
        end else if (len_m == 8'd255 && pc_m == 8'd254) begin
          // stepping to 255 would leave the machine done for good
          issue(1'b0, OP_JMP, 8'($urandom_range(0, 100)), 8'($urandom));
        end else begin
          it = prog[pc_m];
          issue(1'b0, it.opcode, it.opa, it.opb);
        end
      end
      phase++;
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tiny_three_register_cpu_step regression: pass");
    end else begin
      $display("tiny_three_register_cpu_step regression: fail");
    end
    $finish;
  end

  // watchdog, many times the slowest legal run
  initial begin
    #2000000;
    $display("tiny_three_register_cpu_step regression: fail");
    $finish;
  end

endmodule
